@@ design/rlesd_pkg.sv @@
// ----------------------------------------------------------------------------
// rlesd_pkg
// Shared types and constants of the run-length RGB565 sprite decoder.
// ----------------------------------------------------------------------------
package rlesd_pkg;

   localparam int unsigned MAX_WIDTH = 256;

   localparam int unsigned WORD_W  = 16;
   localparam int unsigned RUN_W   = 15;
   localparam int unsigned SKIP_BIT = 15;
   localparam logic [RUN_W-1:0] RUN_MASK = 15'h7FFF;

   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_X    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_Y    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WIDTH       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MODE        = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_MAP_MAIN    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_MAP_SHADOW  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_MAP_MARKING = 3'd7;

   localparam int unsigned RSP_DATA_W = 40;

   // restoring divide of the 16-bit raster index, one quotient bit a cycle
   localparam int unsigned DIV_STEPS = 16;
   localparam int unsigned DIV_CNT_W = 4;

   typedef struct packed {
      logic load;       // latch the accepted item
      logic div_start;  // load divider with the raster index
      logic div_step;   // one divider iteration
      logic div_last;   // final iteration: write column and row
      logic execute;    // apply the latched item to the state
   } cmd_type;

   typedef struct packed {
      logic need_div;   // latched item draws a pixel but position is stale
      logic produce;    // latched item draws a pixel
   } sts_type;

endpackage

@@ design/rlesd_datapath.sv @@
// ----------------------------------------------------------------------------
// rlesd_datapath
// Registers, position counters, divider and pixel formatting of the decoder.
// ----------------------------------------------------------------------------
module rlesd_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  rlesd_pkg::cmd_type                  cmd,
   output rlesd_pkg::sts_type                  sts,
   input  logic [rlesd_pkg::WORD_W-1:0]        word,
   input  logic                                last,
   input  logic                                csr_we,
   input  logic [rlesd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rlesd_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output logic [rlesd_pkg::RSP_DATA_W-1:0]    rsp_data
);

   // configuration
   logic signed [10:0] origin_x_ff, origin_y_ff;
   logic [8:0]         width_ff;
   logic [7:0]         height_ff;
   logic [1:0]         mode_ff;
   logic [31:0]        map_main_ff, map_shadow_ff, map_marking_ff;

   // latched item
   logic [rlesd_pkg::WORD_W-1:0] word_ff;
   logic                         last_ff;

   // decode state
   logic [rlesd_pkg::RUN_W-1:0] left_ff, left_in;
   logic [15:0]                 pix_ff, pix_in;
   logic [7:0]                  col_ff, col_in;
   logic [7:0]                  row_ff, row_in;
   logic                        dirty_ff, dirty_in;

   // divider
   logic [8:0]  rem_ff, rem_in;
   logic [15:0] quo_ff, quo_in;
   logic [9:0]  rem_ext;

   logic [8:0]  w_eff;
   logic [16:0] total;
   logic        active;
   logic [16:0] skip_sum;
   logic [8:0]  col_inc;
   logic [7:0]  col_out;
   logic [11:0] px, py;
   logic [15:0] color;
   logic [rlesd_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   assign w_eff  = (width_ff > 9'(rlesd_pkg::MAX_WIDTH)) ? 9'(rlesd_pkg::MAX_WIDTH) : width_ff;
   assign total  = 17'(w_eff) * 17'(height_ff);
   assign active = {1'b0, pix_ff} < total;

   assign sts.produce  = active && (left_ff != '0);
   assign sts.need_div = active && (left_ff != '0) && dirty_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff    <= '0;
         origin_y_ff    <= '0;
         width_ff       <= 9'd1;
         height_ff      <= 8'd1;
         mode_ff        <= '0;
         map_main_ff    <= '0;
         map_shadow_ff  <= '0;
         map_marking_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            rlesd_pkg::REG_ORIGIN_X:    origin_x_ff    <= csr_wdata[10:0];
            rlesd_pkg::REG_ORIGIN_Y:    origin_y_ff    <= csr_wdata[10:0];
            rlesd_pkg::REG_WIDTH:       width_ff       <= csr_wdata[8:0];
            rlesd_pkg::REG_HEIGHT:      height_ff      <= csr_wdata[7:0];
            rlesd_pkg::REG_MODE:        mode_ff        <= csr_wdata[1:0];
            rlesd_pkg::REG_MAP_MAIN:    map_main_ff    <= csr_wdata;
            rlesd_pkg::REG_MAP_SHADOW:  map_shadow_ff  <= csr_wdata;
            rlesd_pkg::REG_MAP_MARKING: map_marking_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         word_ff <= word;
         last_ff <= last;
      end
   end

   // pixel formatting for the latched literal
   always_comb begin
      col_out = col_ff;
      if (mode_ff[0]) col_out = 8'(w_eff - 9'd1 - {1'b0, col_ff});
      px = 12'(origin_x_ff) + {4'd0, col_out};
      py = 12'(origin_y_ff) + {4'd0, row_ff};
      color = word_ff;
      if (mode_ff[1]) begin
         if (word_ff == map_main_ff[31:16])         color = map_main_ff[15:0];
         else if (word_ff == map_shadow_ff[31:16])  color = map_shadow_ff[15:0];
         else if (word_ff == map_marking_ff[31:16]) color = map_marking_ff[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute && sts.produce) rsp_data_ff <= {color, py, px};
   end
   assign rsp_data = rsp_data_ff;

   // state update
   assign rem_ext  = {rem_ff, quo_ff[15]};
   assign skip_sum = {1'b0, pix_ff} + 17'(word_ff[rlesd_pkg::RUN_W-1:0]);
   assign col_inc  = {1'b0, col_ff} + 9'd1;

   always_comb begin
      left_in  = left_ff;
      pix_in   = pix_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      dirty_in = dirty_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;

      if (cmd.div_start) begin
         rem_in = '0;
         quo_in = pix_ff;
      end
      if (cmd.div_step) begin
         if (rem_ext >= {1'b0, w_eff}) begin
            rem_in = 9'(rem_ext - {1'b0, w_eff});
            quo_in = {quo_ff[14:0], 1'b1};
         end else begin
            rem_in = rem_ext[8:0];
            quo_in = {quo_ff[14:0], 1'b0};
         end
         if (cmd.div_last) begin
            col_in   = rem_in[7:0];
            row_in   = quo_in[7:0];
            dirty_in = 1'b0;
         end
      end

      if (cmd.execute) begin
         if (active) begin
            if (left_ff == '0) begin
               if ((word_ff[rlesd_pkg::RUN_W-1:0] & rlesd_pkg::RUN_MASK) != '0) begin
                  if (word_ff[rlesd_pkg::SKIP_BIT]) begin
                     pix_in   = (skip_sum > total) ? total[15:0] : skip_sum[15:0];
                     dirty_in = 1'b1;
                  end else begin
                     left_in = word_ff[rlesd_pkg::RUN_W-1:0];
                  end
               end
            end else begin
               pix_in  = pix_ff + 16'd1;
               left_in = left_ff - 1'b1;
               if (col_inc == w_eff) begin
                  col_in = '0;
                  row_in = row_ff + 8'd1;
               end else begin
                  col_in = col_inc[7:0];
               end
            end
            if ({1'b0, pix_in} >= total) left_in = '0;
         end else begin
            left_in = '0;
         end
         if (last_ff) begin
            left_in  = '0;
            pix_in   = '0;
            col_in   = '0;
            row_in   = '0;
            dirty_in = 1'b0;
         end
      end

      // a new width invalidates the running column and row
      if (csr_we && csr_index == rlesd_pkg::REG_WIDTH) dirty_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff  <= '0;
         pix_ff   <= '0;
         col_ff   <= '0;
         row_ff   <= '0;
         dirty_ff <= 1'b0;
      end else begin
         left_ff  <= left_in;
         pix_ff   <= pix_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         dirty_ff <= dirty_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

endmodule

@@ design/rlesd_ctrl.sv @@
// ----------------------------------------------------------------------------
// rlesd_ctrl
// Sequencer of the decoder: accept, optional divide, execute, result hold.
// ----------------------------------------------------------------------------
module rlesd_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output rlesd_pkg::cmd_type cmd,
   input  rlesd_pkg::sts_type sts
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;

   logic [1:0]                      state_ff, state_in;
   logic [rlesd_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            cnt_last;

   assign cnt_last   = cnt_ff == rlesd_pkg::DIV_CNT_W'(rlesd_pkg::DIV_STEPS - 1);
   assign req_tready = !reset && (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (sts.need_div) begin
               cmd.div_start = 1'b1;
               cnt_in        = '0;
               state_in      = ST_DIV;
            end else begin
               cmd.execute = 1'b1;
               if (sts.produce) rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cmd.div_last = cnt_last;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_last) state_in = ST_EXEC;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_div_returns: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && cnt_last) |=> state_ff == ST_EXEC)
      else $error("divider did not hand back to execute");

   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EXEC && sts.produce))
      else $error("result raised outside execute");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_tready)
      else $error("item accepted while busy");

   a_exec_slot_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.execute && sts.produce) |-> !rsp_valid_ff)
      else $error("result overwritten before taken");

endmodule

@@ design/rle_rgb565_sprite_decoder.sv @@
// ----------------------------------------------------------------------------
// rle_rgb565_sprite_decoder
// Run-length RGB565 sprite decoder with transparent skips and colour keys.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* carries coded words (run tokens or literal colours); tlast marks
//    the final word of a sprite, after which the decode state returns to zero.
//  - rsp_* carries one item per drawn pixel: screen x, screen y, colour.
//  - csr_* writes the eight registers (origin, size, mode, three key pairs);
//    the user must write them only while no item is in flight; the block does not enforce it.
// Timing:
//  - an item is latched on accept, then executed (after the divider if it runs);
//    no new item is taken meanwhile; a drawn pixel appears on rsp in the cycle after execute.
//  - the first literal after a skip token or a width write first runs the
//    restoring divider (raster index / width, one quotient bit a cycle):
//    one start plus 16 steps before that item executes.
//  - one result register: a new item is taken when it is empty or being
//    taken this cycle, so a stalled receiver holds the input after one
//    drawn pixel.
// Reset: synchronous; registers to defaults (width and height 1), state
// zero, no result pending; req_tready stays low while reset is high.
// ----------------------------------------------------------------------------
module rle_rgb565_sprite_decoder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [rlesd_pkg::WORD_W-1:0]        req_tdata,   // data_word
   input  logic                                req_tlast,   // last_word
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // pixel_x [11:0], pixel_y [23:12], pixel_color [39:24]
   output logic [rlesd_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                                csr_we,
   input  logic [rlesd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rlesd_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   rlesd_pkg::cmd_type cmd;
   rlesd_pkg::sts_type sts;

   rlesd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   rlesd_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .word      (req_tdata),
      .last      (req_tlast),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_data  (rsp_tdata)
   );

endmodule

@@ test/tb_rle_rgb565_sprite_decoder.sv @@
// ----------------------------------------------------------------------------
// tb_rle_rgb565_sprite_decoder
// Self-checking bench for the run-length RGB565 sprite decoder: drives coded
// words with random idling on both streams, predicts every drawn pixel and
// compares each result item field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_rle_rgb565_sprite_decoder;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned TARGET_ITEMS  = 1900;    // input items to send
   localparam int unsigned SETTLE_CYCLES = 24;      // issue + divider + output
   localparam int unsigned CYCLE_LIMIT   = 800000;  // watchdog
   localparam int unsigned HEIGHT_CAP    = 255;

   // result item as it sits on rsp_tdata (last field in the low bits)
   typedef struct packed {
      logic [15:0] color;
      logic [11:0] y;
      logic [11:0] x;
   } pixel_type;

   // one coded word on its way to the req stream
   typedef struct {
      logic [rlesd_pkg::WORD_W-1:0] word;
      logic                         last;
   } coded_item_type;

   // -------------------------------------------------------------------------
   // Pixel scoreboard: own copy of registers and decode state, queue of
   // predicted pixels, field-by-field compare of each result item.
   // -------------------------------------------------------------------------
   class pixel_scoreboard_type;
      logic [10:0] origin_x, origin_y;
      logic [8:0]  sprite_width;
      logic [7:0]  sprite_height;
      logic [1:0]  mode;
      logic [31:0] colour_map [3];
      int unsigned literal_left, pixel_count;
      pixel_type   expected_pixels [$];
      int unsigned error_count;

      function new();
         origin_x = '0;
         origin_y = '0;
         sprite_width = 9'd1;
         sprite_height = 8'd1;
         mode = '0;
         foreach (colour_map[i]) colour_map[i] = '0;
         literal_left = 0;
         pixel_count = 0;
         error_count = 0;
      endfunction

      task report_mismatch(input string what);
         $display("[%0t] mismatch: %s", $realtime, what);
         error_count++;
      endtask

      function void write_reg(input logic [rlesd_pkg::CSR_IDX_W-1:0] idx,
                              input logic [rlesd_pkg::CSR_DATA_W-1:0] value);
         case (idx)
            rlesd_pkg::REG_ORIGIN_X:    origin_x = value[10:0];
            rlesd_pkg::REG_ORIGIN_Y:    origin_y = value[10:0];
            rlesd_pkg::REG_WIDTH:       sprite_width = value[8:0];
            rlesd_pkg::REG_HEIGHT:      sprite_height = value[7:0];
            rlesd_pkg::REG_MODE:        mode = value[1:0];
            rlesd_pkg::REG_MAP_MAIN:    colour_map[0] = value;
            rlesd_pkg::REG_MAP_SHADOW:  colour_map[1] = value;
            rlesd_pkg::REG_MAP_MARKING: colour_map[2] = value;
            default: ;
         endcase
      endfunction

      function int unsigned pending();
         return expected_pixels.size();
      endfunction

      // key pairs are tried main, shadow, marking; first hit wins
      function logic [15:0] remap_colour(input logic [15:0] c);
         if (!mode[1]) return c;
         foreach (colour_map[i])
            if (c == colour_map[i][31:16]) return colour_map[i][15:0];
         return c;
      endfunction

      // Applies one accepted word to the predicted state.
      function void note_word(input logic [rlesd_pkg::WORD_W-1:0] word,
                              input logic last);
         int unsigned w, h, total, p, col, row;
         logic [rlesd_pkg::RUN_W-1:0] run;
         pixel_type pix;
         w = (sprite_width > rlesd_pkg::MAX_WIDTH) ? rlesd_pkg::MAX_WIDTH : sprite_width;
         h = (sprite_height > HEIGHT_CAP) ? HEIGHT_CAP : sprite_height;
         total = w * h;
         run = word[rlesd_pkg::RUN_W-1:0];
         if (pixel_count < total) begin
            if (literal_left == 0) begin
               if (run != '0) begin
                  if (word[rlesd_pkg::SKIP_BIT]) begin
                     p = pixel_count + run;
                     pixel_count = (p > total) ? total : p;
                  end else begin
                     literal_left = run;
                  end
               end
            end else begin
               col = pixel_count % w;
               row = pixel_count / w;
               if (mode[0]) col = w - 1 - col;
               pix.x = {origin_x[10], origin_x} + 12'(col);
               pix.y = {origin_y[10], origin_y} + 12'(row);
               pix.color = remap_colour(word);
               expected_pixels.push_back(pix);
               pixel_count++;
               literal_left--;
            end
            if (pixel_count >= total) literal_left = 0;
         end else begin
            literal_left = 0;
         end
         if (last) begin
            literal_left = 0;
            pixel_count = 0;
         end
      endfunction

      task check_pixel(input pixel_type got);
         pixel_type want;
         if (expected_pixels.size() == 0) begin
            report_mismatch($sformatf("unexpected pixel x=%0d y=%0d colour=%h",
                                      $signed(got.x), $signed(got.y), got.color));
            return;
         end
         want = expected_pixels.pop_front();
         if (got.x !== want.x)
            report_mismatch($sformatf("pixel_x got %0d want %0d",
                                      $signed(got.x), $signed(want.x)));
         if (got.y !== want.y)
            report_mismatch($sformatf("pixel_y got %0d want %0d",
                                      $signed(got.y), $signed(want.y)));
         if (got.color !== want.color)
            report_mismatch($sformatf("pixel_color got %h want %h",
                                      got.color, want.color));
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and DUT
   // -------------------------------------------------------------------------
   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [rlesd_pkg::WORD_W-1:0]     req_tdata = '0;
   logic                             req_tlast = 1'b0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [rlesd_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                             csr_we = 1'b0;
   logic [rlesd_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [rlesd_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   pixel_scoreboard_type sb;
   int unsigned     sent_items = 0;
   int unsigned     cycle_count = 0;
   int              tx_calm = 0;      // items left in a no-gap stretch (sender)
   int              rx_calm = 0;      // same for the receiver
   int unsigned     cur_area = 1;     // width x height of the current setting
   logic [15:0]     cur_keys [3];     // key colours of the current setting

   initial begin
      forever #4 clock = ~clock;
   end

   rle_rgb565_sprite_decoder DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // data_word
      .req_tlast  (req_tlast),    // last_word
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // pixel_x [11:0], pixel_y [23:12], colour [39:24]
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Watchdog: a hung handshake or a lost pixel ends up here.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Regression FAIL");
      $finish;
   end

   // Idle draw: a random gap before each item, with the odd stretch of back-to-back items.
   function automatic int draw_wait(ref int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 31) == 0) begin
         calm = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 19);
   endfunction

   // -------------------------------------------------------------------------
   // Drivers. Every task is entered and left at a falling edge; inputs only
   // move there, handshakes are sampled at the rising edge.
   // -------------------------------------------------------------------------
   task automatic write_reg(input logic [rlesd_pkg::CSR_IDX_W-1:0] idx,
                            input logic [rlesd_pkg::CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_reg(idx, value);
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // writes all eight registers; only called with the block idle
   task automatic program_sprite(input logic [10:0] ox, input logic [10:0] oy,
                                 input logic [8:0] w, input logic [7:0] h,
                                 input logic [1:0] md, input logic [31:0] m_main,
                                 input logic [31:0] m_shadow,
                                 input logic [31:0] m_marking);
      write_reg(rlesd_pkg::REG_ORIGIN_X, 32'(ox));
      write_reg(rlesd_pkg::REG_ORIGIN_Y, 32'(oy));
      write_reg(rlesd_pkg::REG_WIDTH, 32'(w));
      write_reg(rlesd_pkg::REG_HEIGHT, 32'(h));
      write_reg(rlesd_pkg::REG_MODE, 32'(md));
      write_reg(rlesd_pkg::REG_MAP_MAIN, m_main);
      write_reg(rlesd_pkg::REG_MAP_SHADOW, m_shadow);
      write_reg(rlesd_pkg::REG_MAP_MARKING, m_marking);
      cur_area = ((w > rlesd_pkg::MAX_WIDTH) ? rlesd_pkg::MAX_WIDTH : w) * h;
      cur_keys[0] = m_main[31:16];
      cur_keys[1] = m_shadow[31:16];
      cur_keys[2] = m_marking[31:16];
   endtask

   // tvalid is left high after the item goes; the next call either reloads
   // it straight away or drops it, so it only moves once per edge
   task automatic send_word(input logic [rlesd_pkg::WORD_W-1:0] word, input logic last);
      int gap;
      gap = draw_wait(tx_calm);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      req_tlast  <= last;
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.note_word(word, last);
      sent_items++;
      @(negedge clock);
   endtask

   // sender holds off until every predicted pixel is out and the pipe is empty
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Receiver: random stall before each result item, then take it.
   initial begin
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         int stall;
         stall = draw_wait(rx_calm);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         sb.check_pixel(pixel_type'(rsp_tdata));
         @(negedge clock);
      end
   end

   // -------------------------------------------------------------------------
   // Random sprites
   // -------------------------------------------------------------------------
   // a key colour a quarter of the time so the replacement pairs get hit
   function automatic logic [15:0] pick_colour();
      if ($urandom_range(0, 3) == 0) return cur_keys[$urandom_range(0, 2)];
      return 16'($urandom);
   endfunction

   task automatic random_setting();
      logic [10:0] ox, oy;
      logic [8:0]  w;
      logic [7:0]  h;
      logic [15:0] k0, k1, k2;
      case ($urandom_range(0, 7))
         0:       ox = 11'h400;
         1:       ox = 11'h3FF;
         default: ox = 11'($urandom);
      endcase
      case ($urandom_range(0, 7))
         0:       oy = 11'h400;
         1:       oy = 11'h3FF;
         default: oy = 11'($urandom);
      endcase
      // mostly small sprites so that they complete; now and then the largest
      case ($urandom_range(0, 9))
         0:       w = 9'd256;
         1:       w = 9'd1;
         2:       w = 9'($urandom_range(1, 256));
         default: w = 9'($urandom_range(1, 16));
      endcase
      case ($urandom_range(0, 9))
         0:       h = 8'd255;
         1:       h = 8'd1;
         2:       h = 8'($urandom_range(1, 255));
         default: h = 8'($urandom_range(1, 8));
      endcase
      // shared keys now and then, to exercise the main > shadow > marking order
      k0 = 16'($urandom);
      k1 = ($urandom_range(0, 3) == 0) ? k0 : 16'($urandom);
      k2 = ($urandom_range(0, 3) == 0) ? k1 : 16'($urandom);
      program_sprite(ox, oy, w, h, 2'($urandom_range(0, 3)),
                     {k0, 16'($urandom)}, {k1, 16'($urandom)},
                     {k2, 16'($urandom)});
   endtask

   // one coded sprite: mostly well-formed runs, some noise and broken runs
   task automatic random_sprite();
      coded_item_type batch [$];
      coded_item_type it;
      int n_runs, len;
      n_runs = $urandom_range(1, 10);
      it.last = 1'b0;
      repeat (n_runs) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: begin
               len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40)
                                                 : $urandom_range(1, 6);
               it.word = {1'b0, 15'(len)};
               batch.push_back(it);
               repeat (len) begin
                  it.word = pick_colour();
                  batch.push_back(it);
               end
            end
            11, 12, 13, 14, 15: begin
               len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 32767)
                                                 : $urandom_range(1, cur_area / 3 + 1);
               it.word = {1'b1, 15'(len)};
               batch.push_back(it);
            end
            16: begin
               // zero-length token, literal or skip flavour
               it.word = {1'($urandom_range(0, 1)), 15'd0};
               batch.push_back(it);
            end
            17: begin
               // literal run cut short: following tokens read as colours
               it.word = {1'b0, 15'($urandom_range(8, 20))};
               batch.push_back(it);
               repeat ($urandom_range(1, 3)) begin
                  it.word = pick_colour();
                  batch.push_back(it);
               end
            end
            default: begin
               it.word = 16'($urandom);
               batch.push_back(it);
            end
         endcase
      end
      // most sprites close; an open one carries its state into the next one
      if ($urandom_range(0, 9) != 0) batch[$].last = 1'b1;
      foreach (batch[i]) send_word(batch[i].word, batch[i].last);
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      sb = new();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Largest sprite, both origin extremes, keys on: zero tokens, all three
      // key pairs, longest skip, saturating skip, words after completion.
      program_sprite(11'h400, 11'h3FF, 9'd256, 8'd255, 2'd3,
                     32'hF800_001F, 32'h07E0_FFFF, 32'h0000_1234);
      send_word(16'h0000, 1'b0);   // zero literal run, ignored
      send_word(16'h8000, 1'b0);   // zero skip, ignored
      send_word(16'h0004, 1'b0);
      send_word(16'hF800, 1'b0);   // main key
      send_word(16'h07E0, 1'b0);   // shadow key
      send_word(16'h0000, 1'b0);   // marking key
      send_word(16'hFFFF, 1'b0);   // no key matches
      send_word(16'hFFFF, 1'b0);   // skip 0x7FFF
      send_word(16'h0001, 1'b0);
      send_word(16'hABCD, 1'b0);
      send_word(16'hFFFF, 1'b0);   // skip past the end: clamps, sprite complete
      send_word(16'h0003, 1'b0);   // ignored once complete
      send_word(16'hBEEF, 1'b1);   // ignored, clears state
      wait_idle();

      // Mirrored small sprite, main and shadow share a key (main wins), then a
      // width change mid-sprite that leaves the raster index past the end.
      program_sprite(11'h3FF, 11'h400, 9'd5, 8'd3, 2'd3,
                     32'h1111_2222, 32'h1111_3333, 32'h0001_0002);
      send_word(16'h0003, 1'b0);
      send_word(16'h1111, 1'b0);
      send_word(16'h0001, 1'b0);
      send_word(16'h0002, 1'b0);
      send_word(16'h0007, 1'b0);   // literal run left pending
      send_word(16'h0042, 1'b0);
      send_word(16'h0043, 1'b0);
      wait_idle();
      write_reg(rlesd_pkg::REG_WIDTH, 32'd1);
      cur_area = 3;
      send_word(16'h0044, 1'b0);   // sprite now complete: dropped
      send_word(16'h0045, 1'b1);

      // Random phases; each starts with the block drained and a new setting.
      while (sent_items < TARGET_ITEMS) begin
         wait_idle();
         random_setting();
         repeat ($urandom_range(1, 5)) random_sprite();
      end

      wait_idle();
      if (sb.error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

@@ files.f @@
design/rlesd_pkg.sv
design/rlesd_datapath.sv
design/rlesd_ctrl.sv
design/rle_rgb565_sprite_decoder.sv
test/tb_rle_rgb565_sprite_decoder.sv
